// File: design/gap_hold_interpolate_fill_assert.svh
// Assertion macros for the gap fill block checker
`ifndef GAP_HOLD_INTERPOLATE_FILL_ASSERT_SVH
`define GAP_HOLD_INTERPOLATE_FILL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GHIF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghif assertion failed");

// next-cycle implication, disabled during reset
`define GHIF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ghif assertion failed");

`endif

// File: design/ghif_pkg.sv
// Package: widths, constants and types shared by the gap fill block
package ghif_pkg;

  localparam int NUM_CHANNELS = 60;
  localparam int MAX_GAP      = 63;

  localparam int CHAN_W   = 6;
  localparam int RAW_W    = 16;
  localparam int RATIO_W  = 24;
  localparam int VALUE_W  = 40;
  localparam int CNT_W    = 6;
  localparam int DIV_W    = CNT_W + 1;
  localparam int DIFF_W   = VALUE_W + 1;
  localparam int BITCNT_W = $clog2(DIFF_W);
  localparam int IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_SCALE_RATIO = 1'b0;
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);

  localparam logic KIND_VALID  = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] last;
    logic [CNT_W-1:0]   cnt;
  } chan_state_t;

  // one job for the back end: cnt interpolated points, then fin
  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [CNT_W-1:0]   cnt;
    logic [VALUE_W-1:0] last;
    logic [VALUE_W-1:0] fin;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_UPD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_SIGN,
    B_EMIT,
    B_LAST
  } back_state_t;

endpackage

// File: design/ghif_front.sv
// Front end: accepts items, scales samples, keeps per-channel state, issues jobs
module ghif_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [ghif_pkg::CHAN_W-1:0]   in_channel,
  input  logic signed [ghif_pkg::RAW_W-1:0] in_raw_sample,
  input  logic [ghif_pkg::RATIO_W-1:0]  scale_ratio,
  output logic                          push_valid,
  input  logic                          push_stall,
  output ghif_pkg::job_t                push_job
);
  import ghif_pkg::*;

  front_state_t state_r, state_nxt;

  logic                     kind_r;
  logic [CHAN_W-1:0]        chan_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic signed [VALUE_W-1:0] scaled_r;
  logic signed [VALUE_W:0]  prod;

  chan_state_t              mem [NUM_CHANNELS];
  chan_state_t              rd_r;
  logic                     rd_vld_r;
  logic [NUM_CHANNELS-1:0]  vld_r;

  logic [VALUE_W-1:0] last_cur;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   cnt_inc;
  chan_state_t        wr_data;
  logic               accept;
  logic               in_range;
  logic               upd;

  assign accept   = in_valid && !in_stall;
  assign in_range = (in_channel < CHAN_W'(NUM_CHANNELS));
  assign upd      = (state_r == F_UPD) && !push_stall;

  assign prod     = $signed(raw_r) * $signed({1'b0, scale_ratio});
  assign last_cur = rd_vld_r ? rd_r.last : '0;
  assign cnt_cur  = rd_vld_r ? rd_r.cnt : '0;
  assign cnt_inc  = (cnt_cur < CNT_W'(MAX_GAP)) ? cnt_cur + CNT_W'(1) : cnt_cur;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept && in_range) state_nxt = F_READ;
      F_READ: state_nxt = F_UPD;
      F_UPD:  if (!push_stall) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != F_IDLE);
    push_valid = (state_r == F_UPD);
    push_job.chan = chan_r;
    push_job.last = last_cur;
    if (kind_r == KIND_MARKER) begin
      push_job.cnt = '0;
      push_job.fin = last_cur;
      wr_data.last = last_cur;
      wr_data.cnt  = cnt_inc;
    end else begin
      push_job.cnt = cnt_cur;
      push_job.fin = scaled_r;
      wr_data.last = scaled_r;
      wr_data.cnt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (upd) vld_r[chan_r[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      chan_r <= in_channel;
      raw_r  <= in_raw_sample;
    end
    if (state_r == F_READ) begin
      rd_r     <= mem[chan_r[IDX_W-1:0]];
      rd_vld_r <= vld_r[chan_r[IDX_W-1:0]];
      scaled_r <= prod[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (upd) mem[chan_r[IDX_W-1:0]] <= wr_data;
  end

endmodule

// File: design/ghif_queue.sv
// Short job queue between the front and back ends
module ghif_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_stall,
  input  ghif_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_stall,
  output ghif_pkg::job_t pop_job
);
  import ghif_pkg::*;

  job_t               slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    fill_r;
  logic               do_push, do_pop;

  assign push_stall = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_job    = slot[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop)
        fill_r <= fill_r + (QPTR_W+1)'(1);
      else if (do_pop && !do_push)
        fill_r <= fill_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr_r] <= push_job;
  end

endmodule

// File: design/ghif_back.sv
// Back end: bit-serial step divider and result sequencer with output register
module ghif_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_stall,
  input  ghif_pkg::job_t                pop_job,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ghif_pkg::CHAN_W-1:0]   out_channel,
  output logic signed [ghif_pkg::VALUE_W-1:0] out_value,
  output logic                          out_last_of_run
);
  import ghif_pkg::*;

  back_state_t state_r, state_nxt;

  logic [CHAN_W-1:0]   chan_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [VALUE_W-1:0]  acc_r;
  logic [VALUE_W-1:0]  fin_r;
  logic [VALUE_W-1:0]  step_r;
  logic                neg_r;
  logic [DIFF_W-1:0]   q_r;
  logic [DIV_W-1:0]    rem_r;
  logic [DIV_W-1:0]    div_r;
  logic [BITCNT_W-1:0] bit_r;

  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_chan_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_last_r;

  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]   diff_mag;
  logic [DIV_W:0]      rem_sh;
  logic [DIV_W:0]      rem_sub;
  logic                ge;
  logic [VALUE_W-1:0]  acc_next;
  logic                take;
  logic                out_load;

  assign diff     = {fin_r[VALUE_W-1], fin_r} - {acc_r[VALUE_W-1], acc_r};
  assign diff_mag = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
  assign rem_sh   = {rem_r, q_r[DIFF_W-1]};
  assign rem_sub  = rem_sh - {1'b0, div_r};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign acc_next = acc_r + step_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) state_nxt = (pop_job.cnt == '0) ? B_LAST : B_PREP;
      B_PREP: state_nxt = B_DIV;
      B_DIV:  if (bit_r == BITCNT_W'(DIFF_W-1)) state_nxt = B_SIGN;
      B_SIGN: state_nxt = B_EMIT;
      B_EMIT: if (out_load && cnt_r == CNT_W'(1)) state_nxt = B_LAST;
      B_LAST: if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop_stall = (state_r != B_IDLE);
    take      = pop_valid && (state_r == B_IDLE);
    out_load  = ((state_r == B_EMIT) || (state_r == B_LAST)) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: if (take) begin
        chan_r <= pop_job.chan;
        cnt_r  <= pop_job.cnt;
        acc_r  <= pop_job.last;
        fin_r  <= pop_job.fin;
      end
      B_PREP: begin
        neg_r <= diff[DIFF_W-1];
        q_r   <= diff_mag;
        rem_r <= '0;
        div_r <= DIV_W'(cnt_r) + DIV_W'(1);
        bit_r <= '0;
      end
      B_DIV: begin
        q_r   <= {q_r[DIFF_W-2:0], ge};
        rem_r <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        bit_r <= bit_r + BITCNT_W'(1);
      end
      B_SIGN: step_r <= neg_r ? (~q_r[VALUE_W-1:0] + VALUE_W'(1)) : q_r[VALUE_W-1:0];
      B_EMIT: if (out_load) begin
        acc_r <= acc_next;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      B_LAST: ;
      default: ;
    endcase
    if (out_load) begin
      out_chan_r  <= chan_r;
      out_value_r <= (state_r == B_EMIT) ? acc_next : fin_r;
      out_last_r  <= (state_r == B_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_chan_r;
  assign out_value       = out_value_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: design/gap_hold_interpolate_fill.sv
// Top level: gap hold and interpolate fill for a multichannel sample stream
// The front end takes one item at a time (channel state read, scale
// multiply, state write) and runs up to two jobs ahead of the back end. A
// marker or a sample with no pending gaps goes straight to the back end's
// final result; a sample after k gaps first runs the bit-serial step
// divider, then gives one result per cycle while the output is not
// stalled. Channel state is valid-bit tracked, so no clearing pass follows
// reset. Items for channels 60 and above are taken and dropped.
module gap_hold_interpolate_fill (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [ghif_pkg::CHAN_W-1:0]       in_channel,
  input  logic signed [ghif_pkg::RAW_W-1:0] in_raw_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ghif_pkg::CHAN_W-1:0]       out_channel,
  output logic signed [ghif_pkg::VALUE_W-1:0] out_value,
  output logic                              out_last_of_run,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ghif_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ghif_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ghif_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import ghif_pkg::*;

  logic [RATIO_W-1:0] scale_ratio_r;
  logic               push_valid, push_stall;
  logic               pop_valid, pop_stall;
  job_t               push_job, pop_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCALE_RATIO) ? CFG_DATA_W'(scale_ratio_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_ratio_r <= RATIO_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SCALE_RATIO) begin
      scale_ratio_r <= pwdata[RATIO_W-1:0];
    end
  end

  ghif_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_channel    (in_channel),
    .in_raw_sample (in_raw_sample),
    .scale_ratio   (scale_ratio_r),
    .push_valid    (push_valid),
    .push_stall    (push_stall),
    .push_job      (push_job)
  );

  ghif_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_job    (pop_job)
  );

  ghif_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_stall       (pop_stall),
    .pop_job         (pop_job),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel     (out_channel),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: design/ghif_checker.sv
// Port-level checker for the gap fill block, bound to the top level
`include "gap_hold_interpolate_fill_assert.svh"

module ghif_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_kind,
  input logic [ghif_pkg::CHAN_W-1:0]       in_channel,
  input logic signed [ghif_pkg::RAW_W-1:0] in_raw_sample,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ghif_pkg::CHAN_W-1:0]       out_channel,
  input logic signed [ghif_pkg::VALUE_W-1:0] out_value,
  input logic                              out_last_of_run,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [ghif_pkg::CFG_ADDR_W-1:0]   paddr,
  input logic [ghif_pkg::CFG_DATA_W-1:0]   pwdata,
  input logic [ghif_pkg::CFG_DATA_W-1:0]   prdata,
  input logic                              pready
);
  import ghif_pkg::*;

  `GHIF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_channel) && $stable(out_last_of_run))

  `GHIF_ASSERT_NOW(a_out_chan_range, out_valid, out_channel < CHAN_W'(NUM_CHANNELS))

  `GHIF_ASSERT_NEXT(a_in_busy, in_valid && !in_stall && in_channel < CHAN_W'(NUM_CHANNELS), in_stall)

  `GHIF_ASSERT_NEXT(a_ratio_readback, psel && penable && pwrite && pready && paddr[2] == REG_SCALE_RATIO && !(in_kind && !in_kind), prdata == CFG_DATA_W'($past(pwdata[RATIO_W-1:0])) || paddr[2] != REG_SCALE_RATIO)

endmodule

bind gap_hold_interpolate_fill ghif_checker u_ghif_checker (.*);

// File: sim/tb_gap_hold_interpolate_fill.sv
// Self-checking testbench for gap_hold_interpolate_fill: gap hold, interpolation and scaling
module tb_gap_hold_interpolate_fill;
  timeunit 1ns;
  timeprecision 1ps;

  import ghif_pkg::*;

  localparam int STUCK_LIMIT  = 6000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [VALUE_W-1:0] value;
    logic               last;
  } fill_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                        in_valid;
  logic                        in_stall;
  logic                        in_kind;
  logic [CHAN_W-1:0]           in_channel;
  logic signed [RAW_W-1:0]     in_raw_sample;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [CHAN_W-1:0]           out_channel;
  logic signed [VALUE_W-1:0]   out_value;
  logic                        out_last_of_run;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [CFG_ADDR_W-1:0]       paddr;
  logic [CFG_DATA_W-1:0]       pwdata;
  logic [CFG_DATA_W-1:0]       prdata;
  logic                        pready;

  // predictor state
  logic [RATIO_W-1:0]          ratio_reg;
  logic signed [VALUE_W-1:0]   held_value [NUM_CHANNELS];
  int                          gap_count [NUM_CHANNELS];
  fill_beat_t                  fill_values_q [$];

  int err_count = 0;
  int beats_in = 0;
  int results_seen = 0;
  int interp_points = 0;
  int held_emits = 0;
  int ratio_writes = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned stuck_cycles = 0;

  gap_hold_interpolate_fill uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_channel(in_channel), .in_raw_sample(in_raw_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
    .out_value(out_value), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("mismatch %s: got %0h, expected %0h (result beat %0d)",
               what, got, want, results_seen);
    end
  endtask

  task automatic push_fill(input logic [CHAN_W-1:0] chan, input longint v, input logic last);
    fill_beat_t b;
    b.chan  = chan;
    b.value = VALUE_W'(v);
    b.last  = last;
    fill_values_q.insert(fill_values_q.size(), b);
  endtask

  task automatic compute_fill(input logic kind, input logic [CHAN_W-1:0] chan,
                              input logic [RAW_W-1:0] raw);
    longint scaled, prev, step;
    int cnt;
    if (chan >= NUM_CHANNELS) return;
    if (kind == KIND_MARKER) begin
      if (gap_count[chan] < MAX_GAP) gap_count[chan]++;
      held_emits++;
      push_fill(chan, longint'(held_value[chan]), 1'b1);
      return;
    end
    scaled = longint'($signed(raw)) * longint'(ratio_reg);
    prev   = longint'(held_value[chan]);
    cnt    = gap_count[chan];
    if (cnt > 0) begin
      step = (scaled - prev) / longint'(cnt + 1);
      for (int j = 1; j <= cnt; j++) begin
        push_fill(chan, prev + longint'(j) * step, 1'b0);
        interp_points++;
      end
    end
    push_fill(chan, scaled, 1'b1);
    held_value[chan] = VALUE_W'(scaled);
    gap_count[chan]  = 0;
  endtask

  task automatic send_beat(input logic kind, input logic [CHAN_W-1:0] chan,
                           input logic [RAW_W-1:0] raw);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_channel    <= chan;
    in_raw_sample <= raw;
    do @(posedge clk); while (in_stall);
    beats_in++;
    compute_fill(kind, chan, raw);
  endtask

  // sender goes quiet until every predicted beat is back, then lets the front end drain
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (fill_values_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] r);
    wait_all_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_SCALE_RATIO, 2'b00};
    pwdata  <= CFG_DATA_W'(r);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ratio_reg = r;
    ratio_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic test_directed_edges();
    send_beat(KIND_MARKER, 6'd0, 16'h1234);
    send_beat(KIND_MARKER, 6'd59, 16'hFFFF);
    send_beat(KIND_VALID, 6'd0, 16'h7FFF);
    send_beat(KIND_VALID, 6'd59, 16'h8000);
    send_beat(KIND_MARKER, 6'd59, 16'h0000);
    send_beat(KIND_MARKER, 6'd59, 16'h5555);
    send_beat(KIND_VALID, 6'd59, 16'h0000);
    send_beat(KIND_MARKER, 6'd60, 16'hAAAA);
    send_beat(KIND_VALID, 6'd63, 16'h7FFF);
    send_beat(KIND_VALID, 6'd5, 16'hFFFF);
    send_beat(KIND_VALID, 6'd5, 16'h0001);
  endtask

  task automatic test_ratio_extremes();
    write_ratio(24'hFFFFFF);
    send_beat(KIND_MARKER, 6'd1, 16'h0000);
    send_beat(KIND_VALID, 6'd1, 16'h8000);
    send_beat(KIND_VALID, 6'd1, 16'h7FFF);
    write_ratio(24'h000000);
    send_beat(KIND_MARKER, 6'd2, 16'hFFFF);
    send_beat(KIND_VALID, 6'd2, 16'h7FFF);
    send_beat(KIND_VALID, 6'd2, 16'h8000);
    write_ratio(RATIO_RESET);
  endtask

  task automatic test_gap_saturation();
    send_beat(KIND_VALID, 6'd7, rand_raw());
    for (int i = 0; i < MAX_GAP + 3; i++) send_beat(KIND_MARKER, 6'd7, RAW_W'($urandom));
    send_beat(KIND_VALID, 6'd7, rand_raw());
  endtask

  task automatic test_random_fill(input int n_items);
    int sent, gaps;
    logic [CHAN_W-1:0] ch;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(1'($urandom), CHAN_W'($urandom), RAW_W'($urandom));
        sent++;
      end else begin
        ch = ($urandom_range(0, 15) == 0) ? CHAN_W'($urandom_range(60, 63))
                                          : CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
        gaps = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
        for (int i = 0; i < gaps; i++) send_beat(KIND_MARKER, ch, RAW_W'($urandom));
        send_beat(KIND_VALID, ch, rand_raw());
        sent += gaps + 1;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int i = 0; i < 6; i++) begin
      send_beat(KIND_MARKER, CHAN_W'(10 + i), RAW_W'($urandom));
      send_beat(KIND_MARKER, CHAN_W'(10 + i), RAW_W'($urandom));
      send_beat(KIND_VALID, CHAN_W'(10 + i), rand_raw());
    end
    wait_all_results();
    for (int i = 0; i < 4; i++) begin
      send_beat(KIND_MARKER, CHAN_W'(20 + i), RAW_W'($urandom));
      send_beat(KIND_VALID, CHAN_W'(20 + i), rand_raw());
    end
  endtask

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    fill_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (fill_values_q.size() == 0) begin
        report_mismatch("unexpected beat, channel", 64'(out_channel), 64'd0);
      end else begin
        want = fill_values_q.pop_front();
        if (out_channel !== want.chan)
          report_mismatch("out_channel", 64'(out_channel), 64'(want.chan));
        if (out_value !== want.value)
          report_mismatch("out_value", 64'(out_value), 64'(want.value));
        if (out_last_of_run !== want.last)
          report_mismatch("out_last_of_run", 64'(out_last_of_run), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, fill_values_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_VALID;
    in_channel    <= '0;
    in_raw_sample <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    ratio_reg = RATIO_RESET;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      held_value[i] = '0;
      gap_count[i]  = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 23;
    rx_idle_pct <= 64;
    test_directed_edges();
    test_ratio_extremes();
    test_gap_saturation();
    write_ratio(24'($urandom_range(0, 24'hFFFFFF)));
    test_random_fill(110);

    wait_all_results();
    tx_idle_pct = 64;
    rx_idle_pct <= 23;
    write_ratio(24'($urandom_range(1, 255)));
    test_random_fill(110);

    wait_all_results();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    write_ratio(24'hFFFFFF);
    test_random_fill(60);
    write_ratio(RATIO_RESET);
    test_backpressure();

    wait_all_results();
    $display("covered %0d input beats, %0d result beats (%0d held, %0d interpolated)",
             beats_in, results_seen, held_emits, interp_points);
    $display("scale ratio written %0d times, %0d mismatches", ratio_writes, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
